### rtl/core/mbet_pkg.sv
package mbet_pkg;

   localparam int FRAC_BITS = 28;
   localparam int MAX_SIDE  = 4096;

   localparam int COORD_W   = 12;
   localparam int COUNT_W   = 16;
   localparam int SUM_W     = 40;
   localparam int VAL_W     = 32;
   localparam int STEP_W    = 31;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REAL_ORIGIN = 3'd0,
      CSR_IMAG_TOP    = 3'd1,
      CSR_REAL_STEP   = 3'd2,
      CSR_IMAG_STEP   = 3'd3,
      CSR_ITER_LIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic               last_pixel;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] iteration_count;
      logic [SUM_W-1:0]   count_sum;
      logic [COUNT_W-1:0] count_min;
      logic [COUNT_W-1:0] count_max;
      logic               frame_end;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic c_mul;
      logic c_add;
      logic z_mul;
      logic z_step;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic iter_done;
   } dp_status_type;

endpackage

### rtl/core/mbet_ctrl.sv
module mbet_ctrl import mbet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_C_MUL,
      ST_C_ADD,
      ST_Z_MUL,
      ST_Z_TEST,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_C_MUL;
            end
         end
         ST_C_MUL: begin
            cmd.c_mul = 1'b1;
            state_in  = ST_C_ADD;
         end
         ST_C_ADD: begin
            cmd.c_add = 1'b1;
            state_in  = ST_Z_MUL;
         end
         ST_Z_MUL: begin
            cmd.z_mul = 1'b1;
            state_in  = ST_Z_TEST;
         end
         ST_Z_TEST: begin
            if (status.iter_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.z_step = 1'b1;
               state_in   = ST_Z_MUL;
            end
         end
         ST_FINISH: begin
            // stats advance only when the output register can take the result
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/mbet_dp.sv
module mbet_dp import mbet_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_data,
   input  req_type              req_data,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   output rsp_type              rsp_data
);

   localparam int PROD_W = COORD_W + STEP_W;
   localparam int SQ_W   = 2 * VAL_W;
   localparam int WIDE_W = SQ_W + 2;

   localparam logic [COORD_W-1:0] MAX_POS = COORD_W'(MAX_SIDE - 1);
   localparam logic [SQ_W-1:0]    BOUND   = SQ_W'(4) << (2 * FRAC_BITS);

   localparam logic signed [WIDE_W-1:0] SAT_HI =
      $signed({{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
   localparam logic signed [WIDE_W-1:0] SAT_LO =
      $signed({{(WIDE_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});

   localparam logic signed [VAL_W-1:0]  RST_ORIGIN = 32'shE000_0000;
   localparam logic signed [VAL_W-1:0]  RST_TOP    = 32'sh1800_0000;
   localparam logic [STEP_W-1:0]        RST_STEP   = STEP_W'(268525);
   localparam logic [COUNT_W-1:0]       RST_LIMIT  = COUNT_W'(1000);

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[VAL_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] ext_val(input logic signed [VAL_W-1:0] v);
      return $signed({{(WIDE_W-VAL_W){v[VAL_W-1]}}, v});
   endfunction

   function automatic logic signed [WIDE_W-1:0] ext_sq(input logic signed [SQ_W-1:0] v);
      return $signed({{(WIDE_W-SQ_W){v[SQ_W-1]}}, v});
   endfunction

   // configuration
   logic signed [VAL_W-1:0] real_origin_ff, imag_top_ff;
   logic [STEP_W-1:0]       real_step_ff, imag_step_ff;
   logic [COUNT_W-1:0]      limit_ff;

   // item
   logic [COORD_W-1:0]      row_ff, col_ff;
   logic                    last_ff;
   logic [COORD_W-1:0]      row_clamp, col_clamp;
   logic [PROD_W-1:0]       cr_prod_ff, ci_prod_ff;
   logic signed [VAL_W-1:0] cr_ff, ci_ff;
   logic signed [WIDE_W-1:0] cr_sum, ci_sum;

   // iteration
   logic signed [VAL_W-1:0] zr_ff, zi_ff;
   logic signed [SQ_W-1:0]  rr_ff, ii_ff, ri_ff;
   logic [COUNT_W-1:0]      n_ff;
   logic [SQ_W-1:0]         mag;
   logic                    escape;
   logic signed [WIDE_W-1:0] diff, nr_sum, ni_sum;

   // statistics
   logic [SUM_W-1:0]        sum_ff;
   logic [COUNT_W-1:0]      min_ff, max_ff;
   logic [SUM_W:0]          sum_wide;
   logic [SUM_W-1:0]        sum_in;
   logic [COUNT_W-1:0]      min_in, max_in;
   rsp_type                 rsp_ff;

   assign row_clamp = (req_data.row > MAX_POS) ? MAX_POS : req_data.row;
   assign col_clamp = (req_data.column > MAX_POS) ? MAX_POS : req_data.column;

   assign cr_sum = ext_val(real_origin_ff) + $signed({{(WIDE_W-PROD_W){1'b0}}, cr_prod_ff});
   assign ci_sum = ext_val(imag_top_ff) - $signed({{(WIDE_W-PROD_W){1'b0}}, ci_prod_ff});

   // squares are nonnegative, so the sum cannot pass 2^63
   assign mag    = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign escape = mag > BOUND;
   assign status.iter_done = escape || (n_ff >= limit_ff);

   assign diff   = ext_sq(rr_ff) - ext_sq(ii_ff);
   assign nr_sum = (diff >>> FRAC_BITS) + ext_val(cr_ff);
   assign ni_sum = (ext_sq(ri_ff) >>> (FRAC_BITS - 1)) + ext_val(ci_ff);

   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(n_ff);
   assign sum_in   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   assign min_in   = (n_ff < min_ff) ? n_ff : min_ff;
   assign max_in   = (n_ff > max_ff) ? n_ff : max_ff;

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         real_origin_ff <= RST_ORIGIN;
         imag_top_ff    <= RST_TOP;
         real_step_ff   <= RST_STEP;
         imag_step_ff   <= RST_STEP;
         limit_ff       <= RST_LIMIT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REAL_ORIGIN: real_origin_ff <= $signed(csr_data);
            CSR_IMAG_TOP:    imag_top_ff    <= $signed(csr_data);
            CSR_REAL_STEP:   real_step_ff   <= csr_data[STEP_W-1:0];
            CSR_IMAG_STEP:   imag_step_ff   <= csr_data[STEP_W-1:0];
            CSR_ITER_LIMIT:  limit_ff       <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
      end else if (cmd.load_rsp) begin
         if (last_ff) begin
            sum_ff <= '0;
            min_ff <= '1;
            max_ff <= '0;
         end else begin
            sum_ff <= sum_in;
            min_ff <= min_in;
            max_ff <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         row_ff  <= row_clamp;
         col_ff  <= col_clamp;
         last_ff <= req_data.last_pixel;
         zr_ff   <= '0;
         zi_ff   <= '0;
         n_ff    <= '0;
      end
      if (cmd.c_mul) begin
         cr_prod_ff <= PROD_W'(col_ff) * PROD_W'(real_step_ff);
         ci_prod_ff <= PROD_W'(row_ff) * PROD_W'(imag_step_ff);
      end
      if (cmd.c_add) begin
         cr_ff <= sat_val(cr_sum);
         ci_ff <= sat_val(ci_sum);
      end
      if (cmd.z_mul) begin
         rr_ff <= SQ_W'(zr_ff) * SQ_W'(zr_ff);
         ii_ff <= SQ_W'(zi_ff) * SQ_W'(zi_ff);
         ri_ff <= SQ_W'(zr_ff) * SQ_W'(zi_ff);
      end
      if (cmd.z_step) begin
         zr_ff <= sat_val(nr_sum);
         zi_ff <= sat_val(ni_sum);
         n_ff  <= n_ff + COUNT_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_ff.iteration_count <= n_ff;
         rsp_ff.count_sum       <= sum_in;
         rsp_ff.count_min       <= min_in;
         rsp_ff.count_max       <= max_in;
         rsp_ff.frame_end       <= last_ff;
      end
   end

endmodule

### rtl/core/mandelbrot_escape_time_top.sv
// After the input transfer a pixel passes the c multiply and c add states, then loops
// through a multiply state and a test/update state for each z = z^2 + c step, so the
// iteration limit sets the worst case; a finish state then loads the result. A new pixel
// is taken only when idle; a waiting result does not block it until that pixel finishes.
// Reset (synchronous): control idle, config registers back to defaults, statistics cleared.
module mandelbrot_escape_time_top import mbet_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   mbet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbet_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
